### src/lcld_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcld_pkg
// Shared constants and types for the line code level decoder.
// ----------------------------------------------------------------------------
package lcld_pkg;

    localparam int unsigned LevelWidth  = 2;
    localparam int unsigned ModeWidth   = 3;
    localparam int unsigned MaxResults  = 4;
    localparam int unsigned BufDepth    = MaxResults + 1;
    localparam int unsigned BufCntWidth = $clog2(BufDepth + 1);

    localparam logic [LevelWidth-1:0] LV_ZERO = 2'd0;
    localparam logic [LevelWidth-1:0] LV_HIGH = 2'd1;
    localparam logic [LevelWidth-1:0] LV_LOW  = 2'd2;
    localparam logic [LevelWidth-1:0] LV_IDLE = 2'd3;

    localparam logic [LevelWidth-1:0] PULSE_NONE = 2'd0;

    localparam logic [ModeWidth-1:0] CODE_NRZ_A = 3'd0;
    localparam logic [ModeWidth-1:0] CODE_NRZ_B = 3'd1;
    localparam logic [ModeWidth-1:0] CODE_AMI_A = 3'd2;
    localparam logic [ModeWidth-1:0] CODE_AMI_B = 3'd3;
    localparam logic [ModeWidth-1:0] CODE_HDB3  = 3'd4;
    localparam logic [ModeWidth-1:0] CODE_CMI   = 3'd5;

    localparam logic [1:0] WINDOW_FULL = 2'd3;

    typedef struct packed {
        logic [2:0]            count;
        logic [MaxResults-1:0] data;
        logic [MaxResults-1:0] fin;
    } lcld_results_t;

endpackage
`default_nettype wire

### src/lcld_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lcld_core
// Decoder state and three-bit hold window; produces the result beats of the
// current input beat and updates its state when the beat is accepted.
// ----------------------------------------------------------------------------
module lcld_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [lcld_pkg::ModeWidth-1:0]  code_mode,
    input  wire logic                            in_accept,
    input  wire logic [lcld_pkg::LevelWidth-1:0] level,
    input  wire logic                            end_of_stream,
    output lcld_pkg::lcld_results_t              results
);
    import lcld_pkg::*;

    logic [LevelWidth-1:0] prev_level_reg, prev_level_next;
    logic [LevelWidth-1:0] prev_pulse_reg, prev_pulse_next;
    logic                  await_pulse_reg, await_pulse_next;
    logic                  await_viol_reg, await_viol_next;
    logic [2:0]            held_bits_reg, held_bits_next;
    logic [1:0]            held_cnt_reg, held_cnt_next;

    always_comb begin
        logic [LevelWidth-1:0] lv;
        logic                  pulse;
        logic                  push;
        logic                  bit_val;
        logic                  correct;
        logic                  release_en;
        logic                  release_bit;
        logic [1:0]            k;
        logic [1:0]            idx;
        logic [1:0]            pos;

        lv = (level == LV_IDLE) ? LV_ZERO : level;
        pulse = (lv == LV_HIGH) || (lv == LV_LOW);
        push = 1'b0;
        bit_val = 1'b0;
        correct = 1'b0;
        idx = 2'd0;
        pos = 2'd0;
        prev_level_next = prev_level_reg;
        prev_pulse_next = prev_pulse_reg;
        await_pulse_next = await_pulse_reg;
        await_viol_next = await_viol_reg;

        case (code_mode)
            CODE_NRZ_A, CODE_NRZ_B: begin
                push = 1'b1;
                bit_val = (lv == LV_HIGH);
            end
            CODE_AMI_A, CODE_AMI_B: begin
                if (pulse) begin
                    push = 1'b1;
                    bit_val = 1'b1;
                    prev_level_next = lv;
                end else if (prev_level_reg == lv) begin
                    push = 1'b1;
                    prev_level_next = LV_IDLE;
                end else begin
                    prev_level_next = lv;
                end
            end
            CODE_HDB3: begin
                if (!pulse) begin
                    if (prev_level_reg == LV_ZERO) begin
                        push = 1'b1;
                        prev_level_next = LV_IDLE;
                    end else begin
                        prev_level_next = lv;
                    end
                end else begin
                    push = 1'b1;
                    if (await_pulse_reg) begin
                        if (lv == LV_HIGH) begin
                            bit_val = 1'b1;
                        end else begin
                            await_viol_next = 1'b0;
                        end
                        await_pulse_next = 1'b0;
                    end else if (prev_pulse_reg == lv) begin
                        if (await_viol_reg) begin
                            await_viol_next = 1'b0;
                        end else begin
                            correct = 1'b1;
                        end
                    end else begin
                        bit_val = 1'b1;
                    end
                    prev_pulse_next = lv;
                    prev_level_next = lv;
                end
            end
            CODE_CMI: begin
                if (lv == LV_HIGH) begin
                    if (prev_level_reg == LV_ZERO) begin
                        push = 1'b1;
                        prev_level_next = lv;
                    end else if (prev_level_reg == LV_HIGH) begin
                        push = 1'b1;
                        bit_val = 1'b1;
                        prev_level_next = LV_IDLE;
                    end else begin
                        prev_level_next = lv;
                    end
                end else begin
                    if (prev_level_reg == LV_ZERO) begin
                        push = 1'b1;
                        bit_val = 1'b1;
                        prev_level_next = LV_IDLE;
                    end else begin
                        prev_level_next = lv;
                    end
                end
            end
            default: begin
            end
        endcase

        release_en = push && (held_cnt_reg == WINDOW_FULL);
        release_bit = held_bits_reg[2] && !correct;
        held_bits_next = held_bits_reg;
        held_cnt_next = held_cnt_reg;
        if (push) begin
            held_bits_next = {held_bits_reg[1:0], bit_val};
            if (!release_en) begin
                held_cnt_next = held_cnt_reg + 2'd1;
            end
        end

        results.count = 3'd0;
        results.data = '0;
        results.fin = '0;
        k = 2'd0;
        if (release_en) begin
            results.data[0] = release_bit;
            results.count = 3'd1;
            k = 2'd1;
        end
        if (end_of_stream) begin
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < held_cnt_next) begin
                    idx = k + 2'(j);
                    pos = held_cnt_next - 2'd1 - 2'(j);
                    results.data[idx] = held_bits_next[pos];
                    results.fin[idx] = (2'(j) == held_cnt_next - 2'd1);
                end
            end
            results.count = 3'(k) + 3'(held_cnt_next);
            prev_level_next = LV_IDLE;
            prev_pulse_next = PULSE_NONE;
            await_pulse_next = 1'b1;
            await_viol_next = 1'b1;
            held_bits_next = 3'd0;
            held_cnt_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_level_reg <= LV_IDLE;
            prev_pulse_reg <= PULSE_NONE;
            await_pulse_reg <= 1'b1;
            await_viol_reg <= 1'b1;
            held_bits_reg <= 3'd0;
            held_cnt_reg <= 2'd0;
        end else if (in_accept) begin
            prev_level_reg <= prev_level_next;
            prev_pulse_reg <= prev_pulse_next;
            await_pulse_reg <= await_pulse_next;
            await_viol_reg <= await_viol_next;
            held_bits_reg <= held_bits_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

endmodule
`default_nettype wire

### src/line_code_level_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_code_level_decoder_top
// Decodes received line levels (NRZ, RZ/AMI, HDB3, CMI) into data bits.
// ----------------------------------------------------------------------------
// One level is taken per beat and every cycle is accepted while at most one
// decoded bit waits at the output, so ordinary streams run at one beat per
// cycle. Decoded bits pass through a three-bit hold window, so the first
// bits appear three bits late. A beat marked end of stream flushes the window
// and can yield up to four result beats; these drain one per cycle while
// m_ready is high from a five-entry output queue, and the input stalls until
// the queue holds at most one bit again. The code mode register is written
// through its own channel and must only change while the block is idle.
module line_code_level_decoder_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lcld_pkg::ModeWidth-1:0]  cfg_code_mode,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lcld_pkg::LevelWidth-1:0] s_level,
    input  wire logic                            s_end_of_stream,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic                                 m_data_bit,
    output logic                                 m_final_bit
);
    import lcld_pkg::*;

    logic [ModeWidth-1:0]   code_mode_reg;
    logic [BufDepth-1:0]    buf_data_reg, buf_data_next;
    logic [BufDepth-1:0]    buf_fin_reg, buf_fin_next;
    logic [BufCntWidth-1:0] buf_cnt_reg, buf_cnt_next;
    logic                   in_accept;
    logic                   pop;
    lcld_results_t          results;

    assign cfg_ready = 1'b1;
    assign s_ready = (buf_cnt_reg <= BufCntWidth'(1));
    assign in_accept = s_valid && s_ready;
    assign m_valid = (buf_cnt_reg != '0);
    assign m_data_bit = buf_data_reg[0];
    assign m_final_bit = buf_fin_reg[0];
    assign pop = m_valid && m_ready;

    lcld_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .code_mode     (code_mode_reg),
        .in_accept     (in_accept),
        .level         (s_level),
        .end_of_stream (s_end_of_stream),
        .results       (results)
    );

    always_comb begin
        logic [BufCntWidth-1:0] base;
        logic [BufCntWidth-1:0] off;
        logic [BufCntWidth-1:0] n_new;

        base = buf_cnt_reg - BufCntWidth'(pop);
        n_new = in_accept ? BufCntWidth'(results.count) : '0;
        for (int i = 0; i < BufDepth; i++) begin
            if (pop) begin
                buf_data_next[i] = (i < BufDepth - 1) ? buf_data_reg[(i + 1) % BufDepth] : 1'b0;
                buf_fin_next[i] = (i < BufDepth - 1) ? buf_fin_reg[(i + 1) % BufDepth] : 1'b0;
            end else begin
                buf_data_next[i] = buf_data_reg[i];
                buf_fin_next[i] = buf_fin_reg[i];
            end
            off = BufCntWidth'(i) - base;
            if ((BufCntWidth'(i) >= base) && (off < n_new)) begin
                buf_data_next[i] = results.data[off[1:0]];
                buf_fin_next[i] = results.fin[off[1:0]];
            end
        end
        buf_cnt_next = base + n_new;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_mode_reg <= CODE_NRZ_A;
            buf_cnt_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                code_mode_reg <= cfg_code_mode;
            end
            buf_cnt_reg <= buf_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        buf_data_reg <= buf_data_next;
        buf_fin_reg <= buf_fin_next;
    end

endmodule
`default_nettype wire
